/* rtl/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants, command codes and types of the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

   localparam int VERTEX_DEPTH = 1024;
   localparam int FACE_DEPTH   = 1024;
   localparam int COORD_BITS   = 16;

   localparam int IDX_BITS  = 10;
   localparam int VAW       = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int FAW       = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
   localparam int EW        = COORD_BITS + 1;       // edge component
   localparam int PW        = 2 * EW;               // one cross term
   localparam int CW        = PW + 1;               // cross component
   localparam int AW        = (CW > 31) ? CW : 31;  // magnitude, scaled
   localparam int NORM_BITS = 16;
   localparam int Q_BITS    = 16;
   localparam int ONE_Q14   = 16384;

   localparam logic [1:0] CMD_VERTEX = 2'd0;
   localparam logic [1:0] CMD_FACE   = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef logic signed [EW-1:0] edge_type;

   typedef struct packed {
      edge_type e1x;
      edge_type e1y;
      edge_type e1z;
      edge_type e2x;
      edge_type e2y;
      edge_type e2z;
   } edges_type;

   typedef struct packed {
      logic start;
      logic ack;
   } calc_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } calc_sts_type;

   typedef struct packed {
      logic signed [NORM_BITS-1:0] nx;
      logic signed [NORM_BITS-1:0] ny;
      logic signed [NORM_BITS-1:0] nz;
      logic                        deg;
   } result_type;

endpackage

/* rtl/tfn_ram.sv */
// ----------------------------------------------------------------------------
// tfn_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tfn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [ABITS-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [ABITS-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tfn_calc.sv */
// ----------------------------------------------------------------------------
// tfn_calc
// Cross product, block scaling, squared norm, bit-serial square root and
// restoring division around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module tfn_calc (
   input  logic                  clock,
   input  logic                  reset,
   input  tfn_pkg::calc_ctl_type ctl,
   input  tfn_pkg::edges_type    edges,
   output tfn_pkg::calc_sts_type sts,
   output tfn_pkg::result_type   result
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL    = 4'd1;
   localparam logic [3:0] S_ACC    = 4'd2;
   localparam logic [3:0] S_MAG    = 4'd3;
   localparam logic [3:0] S_SCALE  = 4'd4;
   localparam logic [3:0] S_RINIT  = 4'd5;
   localparam logic [3:0] S_ROOT   = 4'd6;
   localparam logic [3:0] S_RFIN   = 4'd7;
   localparam logic [3:0] S_DINIT  = 4'd8;
   localparam logic [3:0] S_DSTEP  = 4'd9;
   localparam logic [3:0] S_DSTORE = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   localparam int AW = tfn_pkg::AW;
   localparam int CW = tfn_pkg::CW;
   localparam int NB = tfn_pkg::NORM_BITS;
   localparam int QB = tfn_pkg::Q_BITS;

   logic [3:0]                state_ff;
   logic [3:0]                step_ff;
   logic signed [CW-1:0]      c_ff [3];
   logic [AW-1:0]             a_ff [3];
   logic                      neg_ff [3];
   logic [AW-1:0]             m_ff;
   logic [63:0]               n_ff;
   logic signed [63:0]        prod_ff;
   logic [63:0]               rem_ff;
   logic [63:0]               root_ff;
   logic [63:0]               bit_ff;
   logic [4:0]                rcnt_ff;
   logic [31:0]               r_ff;
   logic [47:0]               drem_ff;
   logic [47:0]               dvs_ff;
   logic [QB-1:0]             q_ff;
   logic [3:0]                dcnt_ff;
   logic [1:0]                comp_ff;
   logic signed [NB-1:0]      nrm_ff [3];
   logic                      deg_ff;

   logic signed [31:0]        op_a;
   logic signed [31:0]        op_b;
   logic signed [AW-1:0]      c_ext [3];
   logic [AW-1:0]             mag [3];
   logic [AW-1:0]             mag_max;
   logic [63:0]               root_trial;
   logic [QB-1:0]             q_sat;

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         4'd0: begin op_a = 32'(edges.e1y); op_b = 32'(edges.e2z); end
         4'd1: begin op_a = 32'(edges.e1z); op_b = 32'(edges.e2y); end
         4'd2: begin op_a = 32'(edges.e1z); op_b = 32'(edges.e2x); end
         4'd3: begin op_a = 32'(edges.e1x); op_b = 32'(edges.e2z); end
         4'd4: begin op_a = 32'(edges.e1x); op_b = 32'(edges.e2y); end
         4'd5: begin op_a = 32'(edges.e1y); op_b = 32'(edges.e2x); end
         4'd6: begin op_a = 32'(a_ff[0]);   op_b = 32'(a_ff[0]);   end
         4'd7: begin op_a = 32'(a_ff[1]);   op_b = 32'(a_ff[1]);   end
         4'd8: begin op_a = 32'(a_ff[2]);   op_b = 32'(a_ff[2]);   end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_ext[k] = AW'(c_ff[k]);
         mag[k]   = c_ff[k][CW-1] ? AW'(-c_ext[k]) : AW'(c_ext[k]);
      end
      mag_max = mag[0];
      if (mag[1] > mag_max) mag_max = mag[1];
      if (mag[2] > mag_max) mag_max = mag[2];
   end

   assign root_trial = root_ff + bit_ff;
   assign q_sat = (q_ff > QB'(tfn_pkg::ONE_Q14)) ? QB'(tfn_pkg::ONE_Q14) : q_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               for (int k = 0; k < 3; k++) c_ff[k] <= '0;
               step_ff  <= '0;
               state_ff <= S_MUL;
            end
         end
         S_MUL: begin
            state_ff <= S_ACC;
         end
         S_ACC: begin
            if (step_ff < 4'd6) begin
               if (step_ff[0]) begin
                  c_ff[step_ff[2:1]] <= c_ff[step_ff[2:1]] - prod_ff[CW-1:0];
               end else begin
                  c_ff[step_ff[2:1]] <= c_ff[step_ff[2:1]] + prod_ff[CW-1:0];
               end
            end else begin
               n_ff <= n_ff + 64'(prod_ff);
            end
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'd5) begin
               state_ff <= S_MAG;
            end else if (step_ff == 4'd8) begin
               state_ff <= S_RINIT;
            end else begin
               state_ff <= S_MUL;
            end
         end
         S_MAG: begin
            for (int k = 0; k < 3; k++) begin
               a_ff[k]   <= mag[k];
               neg_ff[k] <= c_ff[k][CW-1];
            end
            m_ff <= mag_max;
            if (mag_max == '0) begin
               for (int k = 0; k < 3; k++) nrm_ff[k] <= '0;
               deg_ff   <= 1'b1;
               state_ff <= S_DONE;
            end else begin
               deg_ff   <= 1'b0;
               state_ff <= S_SCALE;
            end
         end
         S_SCALE: begin
            // one bit a cycle until the largest magnitude sits in [2^29, 2^30)
            if ((m_ff >> 30) != '0) begin
               m_ff <= m_ff >> 1;
               for (int k = 0; k < 3; k++) a_ff[k] <= a_ff[k] >> 1;
            end else if (!m_ff[29]) begin
               m_ff <= m_ff << 1;
               for (int k = 0; k < 3; k++) a_ff[k] <= a_ff[k] << 1;
            end else begin
               n_ff     <= '0;
               state_ff <= S_MUL;
            end
         end
         S_RINIT: begin
            rem_ff   <= n_ff;
            root_ff  <= '0;
            bit_ff   <= 64'd1 << 62;
            rcnt_ff  <= '0;
            state_ff <= S_ROOT;
         end
         S_ROOT: begin
            if (rem_ff >= root_trial) begin
               rem_ff  <= rem_ff - root_trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            rcnt_ff <= rcnt_ff + 5'd1;
            if (rcnt_ff == 5'd31) state_ff <= S_RFIN;
         end
         S_RFIN: begin
            r_ff     <= (root_ff == '0) ? 32'd1 : root_ff[31:0];
            comp_ff  <= '0;
            state_ff <= S_DINIT;
         end
         S_DINIT: begin
            drem_ff  <= (48'(a_ff[comp_ff]) << 14) + 48'(r_ff >> 1);
            dvs_ff   <= 48'(r_ff) << (QB - 1);
            q_ff     <= '0;
            dcnt_ff  <= '0;
            state_ff <= S_DSTEP;
         end
         S_DSTEP: begin
            if (drem_ff >= dvs_ff) begin
               drem_ff <= drem_ff - dvs_ff;
               q_ff    <= {q_ff[QB-2:0], 1'b1};
            end else begin
               q_ff    <= {q_ff[QB-2:0], 1'b0};
            end
            dvs_ff  <= dvs_ff >> 1;
            dcnt_ff <= dcnt_ff + 4'd1;
            if (dcnt_ff == 4'(QB - 1)) state_ff <= S_DSTORE;
         end
         S_DSTORE: begin
            nrm_ff[comp_ff] <= neg_ff[comp_ff] ? -NB'(q_sat) : NB'(q_sat);
            if (comp_ff == 2'd2) begin
               state_ff <= S_DONE;
            end else begin
               comp_ff  <= comp_ff + 2'd1;
               state_ff <= S_DINIT;
            end
         end
         S_DONE: begin
            if (ctl.ack) state_ff <= S_IDLE;
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
      end
   end

   assign sts.busy   = (state_ff != S_IDLE);
   assign sts.done   = (state_ff == S_DONE);
   assign result.nx  = nrm_ff[0];
   assign result.ny  = nrm_ff[1];
   assign result.nz  = nrm_ff[2];
   assign result.deg = deg_ff;

endmodule

/* rtl/triangle_face_normal_top.sv */
// ----------------------------------------------------------------------------
// triangle_face_normal_top
// Vertex and face stores with a query path that returns a face's unit normal.
// ----------------------------------------------------------------------------
// Loads give no result; the next transaction may follow at once.
// A query is answered after these steps in order: fetch, cross product on the shared multiplier,
// magnitude, block scaling, squared norm, square root, the three 16-step divisions and
// the move into the output register; a degenerate face skips from magnitude to the output.
// The input stays closed while a query runs or its result waits for the output register.
// Reset (synchronous) clears control only; both stores are undefined until written.
module triangle_face_normal_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic [9:0]                          req_slot,
   input  logic signed [15:0]                  req_coord_x,
   input  logic signed [15:0]                  req_coord_y,
   input  logic signed [15:0]                  req_coord_z,
   input  logic [9:0]                          req_corner_a,
   input  logic [9:0]                          req_corner_b,
   input  logic [9:0]                          req_corner_c,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_normal_x,
   output logic signed [15:0]                  rsp_normal_y,
   output logic signed [15:0]                  rsp_normal_z,
   output logic                                rsp_degenerate
);

   localparam int CB  = tfn_pkg::COORD_BITS;
   localparam int EW  = tfn_pkg::EW;
   localparam int VAW = tfn_pkg::VAW;
   localparam int FAW = tfn_pkg::FAW;
   localparam int IB  = tfn_pkg::IDX_BITS;

   // fetch sequencer codes
   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_FACE = 3'd1;
   localparam logic [2:0] F_VA   = 3'd2;
   localparam logic [2:0] F_VB   = 3'd3;
   localparam logic [2:0] F_VC   = 3'd4;
   localparam logic [2:0] F_GO   = 3'd5;

   logic [2:0]               fetch_ff;
   logic                     slot_ok_ff;
   logic                     vtx_ok_ff;
   logic [IB-1:0]            cb_ff;
   logic [IB-1:0]            cc_ff;
   logic signed [EW-1:0]     v1_ff [3];
   tfn_pkg::edges_type       edges_ff;

   logic                     rsp_valid_ff;
   tfn_pkg::result_type      rsp_res_ff;

   logic                     req_take;
   logic [31:0]              slot_ext;
   logic [3*CB-1:0]          vtx_wr_data;
   logic [3*IB-1:0]          face_wr_data;
   logic [3*CB-1:0]          vtx_rd_data;
   logic [3*IB-1:0]          face_rd_data;
   logic [VAW-1:0]           vtx_rd_addr;
   logic [IB-1:0]            corner_a;
   logic [IB-1:0]            corner_b;
   logic [IB-1:0]            corner_c;
   logic [31:0]              rd_corner_ext;
   logic [IB-1:0]            rd_corner;
   logic signed [EW-1:0]     vtx [3];

   tfn_pkg::calc_ctl_type    calc_ctl;
   tfn_pkg::calc_sts_type    calc_sts;
   tfn_pkg::result_type      calc_res;

   // take a transaction only with the fetch idle and the engine free
   assign req_ready = (fetch_ff == F_IDLE) && !calc_sts.busy;
   assign req_take  = req_valid && req_ready;
   assign slot_ext  = 32'(req_slot);

   assign vtx_wr_data  = {req_coord_z[CB-1:0], req_coord_y[CB-1:0], req_coord_x[CB-1:0]};
   assign face_wr_data = {req_corner_c, req_corner_b, req_corner_a};

   tfn_ram #(
      .WIDTH (3 * CB),
      .DEPTH (tfn_pkg::VERTEX_DEPTH)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (req_take && (req_command == tfn_pkg::CMD_VERTEX)
                && (slot_ext < 32'(tfn_pkg::VERTEX_DEPTH))),
      .wr_addr (slot_ext[VAW-1:0]),
      .wr_data (vtx_wr_data),
      .rd_addr (vtx_rd_addr),
      .rd_data (vtx_rd_data)
   );

   tfn_ram #(
      .WIDTH (3 * IB),
      .DEPTH (tfn_pkg::FACE_DEPTH)
   ) u_face_ram (
      .clock   (clock),
      .wr_en   (req_take && (req_command == tfn_pkg::CMD_FACE)
                && (slot_ext < 32'(tfn_pkg::FACE_DEPTH))),
      .wr_addr (slot_ext[FAW-1:0]),
      .wr_data (face_wr_data),
      .rd_addr (slot_ext[FAW-1:0]),
      .rd_data (face_rd_data)
   );

   // a face slot past the table reads as three zero corners
   assign corner_a = slot_ok_ff ? face_rd_data[IB-1:0]      : '0;
   assign corner_b = slot_ok_ff ? face_rd_data[2*IB-1:IB]   : '0;
   assign corner_c = slot_ok_ff ? face_rd_data[3*IB-1:2*IB] : '0;

   // pick which corner's vertex to read this cycle
   always_comb begin
      case (fetch_ff)
         F_FACE:  rd_corner = corner_a;
         F_VA:    rd_corner = cb_ff;
         F_VB:    rd_corner = cc_ff;
         default: rd_corner = '0;
      endcase
   end
   assign rd_corner_ext = 32'(rd_corner);
   assign vtx_rd_addr   = rd_corner_ext[VAW-1:0];

   // sign-extend the stored coordinates; a corner past the store reads as origin
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vtx[k] = vtx_ok_ff ? $signed({vtx_rd_data[k*CB+CB-1], vtx_rd_data[k*CB +: CB]})
                            : '0;
      end
   end

   always_ff @(posedge clock) begin
      case (fetch_ff)
         F_IDLE: begin
            if (req_take && (req_command == tfn_pkg::CMD_QUERY)) begin
               slot_ok_ff <= (slot_ext < 32'(tfn_pkg::FACE_DEPTH));
               fetch_ff   <= F_FACE;
            end
         end
         F_FACE: begin
            cb_ff     <= corner_b;
            cc_ff     <= corner_c;
            vtx_ok_ff <= (rd_corner_ext < 32'(tfn_pkg::VERTEX_DEPTH));
            fetch_ff  <= F_VA;
         end
         F_VA: begin
            for (int k = 0; k < 3; k++) v1_ff[k] <= vtx[k];
            vtx_ok_ff <= (rd_corner_ext < 32'(tfn_pkg::VERTEX_DEPTH));
            fetch_ff  <= F_VB;
         end
         F_VB: begin
            edges_ff.e1x <= vtx[0] - v1_ff[0];
            edges_ff.e1y <= vtx[1] - v1_ff[1];
            edges_ff.e1z <= vtx[2] - v1_ff[2];
            vtx_ok_ff    <= (rd_corner_ext < 32'(tfn_pkg::VERTEX_DEPTH));
            fetch_ff     <= F_VC;
         end
         F_VC: begin
            edges_ff.e2x <= vtx[0] - v1_ff[0];
            edges_ff.e2y <= vtx[1] - v1_ff[1];
            edges_ff.e2z <= vtx[2] - v1_ff[2];
            fetch_ff     <= F_GO;
         end
         F_GO: begin
            fetch_ff <= F_IDLE;
         end
         default: begin
            fetch_ff <= F_IDLE;
         end
      endcase
      if (reset) begin
         fetch_ff <= F_IDLE;
      end
   end

   assign calc_ctl.start = (fetch_ff == F_GO);
   // hand the result over when the output register is empty or being drained
   assign calc_ctl.ack   = calc_sts.done && (!rsp_valid_ff || rsp_ready);

   tfn_calc u_calc (
      .clock  (clock),
      .reset  (reset),
      .ctl    (calc_ctl),
      .edges  (edges_ff),
      .sts    (calc_sts),
      .result (calc_res)
   );

   // output register: hold the result until the transaction completes
   always_ff @(posedge clock) begin
      if (calc_ctl.ack) begin
         rsp_res_ff   <= calc_res;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = rsp_res_ff.nx;
   assign rsp_normal_y   = rsp_res_ff.ny;
   assign rsp_normal_z   = rsp_res_ff.nz;
   assign rsp_degenerate = rsp_res_ff.deg;

   // a degenerate face always reports the zero vector
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
      (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("degenerate result with nonzero normal");

   // components never exceed one in Q1.14
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= 16'sd16384 && rsp_normal_x >= -16'sd16384 &&
                     rsp_normal_y <= 16'sd16384 && rsp_normal_y >= -16'sd16384 &&
                     rsp_normal_z <= 16'sd16384 && rsp_normal_z >= -16'sd16384))
      else $error("normal component out of range");

   // an accepted query closes the input until its fetch is done
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_command == tfn_pkg::CMD_QUERY) |=> !req_ready)
      else $error("input open during a query fetch");

   // the engine is never started while it still works
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      calc_ctl.start |-> !calc_sts.busy)
      else $error("engine started while busy");

endmodule
